>>> hw/rtl/taim_pkg.sv
// Shared widths, codes and beat types for the triangle inverse mapping block.
// No dependencies; imported by every module of the block.
package taim_pkg;

   // lattice bound and field widths
   localparam int MAX_GRID  = 512;
   localparam int H_W       = $clog2(MAX_GRID + 1);
   localparam int ROW_W     = $clog2(MAX_GRID);
   localparam int ID_W      = 20;
   localparam int CELL_W    = ID_W - 2;
   localparam int CRD_W     = 32;

   // datapath widths
   localparam int DIF_W     = CRD_W + 1;
   localparam int PRD_W     = 2 * DIF_W;
   localparam int CRS_W     = PRD_W + 1;
   localparam int SUM_W     = CRS_W + 3;
   localparam int NUM_W     = SUM_W + 15;
   localparam int MAG_W     = NUM_W - 1;
   localparam int DEN_W     = CRS_W;

   // quotient: 41 bits, clamp at 2^40
   localparam int FRAC_STEPS = 41;
   localparam int FRAC_LAT   = FRAC_STEPS + 2;
   localparam int CELL_STEPS = CELL_W;
   localparam int CELL_DELAY = 4 + FRAC_LAT - CELL_STEPS;

   // triangle kinds around the cell center
   localparam logic [1:0] KIND_BOTTOM = 2'd0;
   localparam logic [1:0] KIND_LEFT   = 2'd1;
   localparam logic [1:0] KIND_RIGHT  = 2'd2;
   localparam logic [1:0] KIND_TOP    = 2'd3;

   typedef struct packed {
      logic [CELL_W-1:0] col;
      logic [ROW_W-1:0]  row;
      logic [1:0]        kind;
   } cell_res_type;

   typedef struct packed {
      logic valid;
      logic neg_x;
      logic neg_y;
      logic zero;
   } side_type;

   typedef struct packed {
      logic [ID_W-1:0]         id;
      logic signed [CRD_W-1:0] v0x;
      logic signed [CRD_W-1:0] v0y;
      logic signed [CRD_W-1:0] v1x;
      logic signed [CRD_W-1:0] v1y;
      logic signed [CRD_W-1:0] v2x;
      logic signed [CRD_W-1:0] v2y;
      logic signed [CRD_W-1:0] ptx;
      logic signed [CRD_W-1:0] pty;
   } in_beat_type;

endpackage

>>> hw/rtl/taim_cell_div.sv
// Pipelined restoring divider: cell number by grid height, one quotient bit per stage.
// Depends on taim_pkg.
module taim_cell_div (
   input  logic                        clock,
   input  logic                        en,
   input  logic [taim_pkg::CELL_W-1:0] cell_in,
   input  logic [taim_pkg::H_W-1:0]    h_in,
   input  logic [1:0]                  kind_in,
   output taim_pkg::cell_res_type      res
);
   import taim_pkg::*;

   localparam int CMP_W = CELL_W + H_W;

   logic [CELL_W-1:0] rem_ff  [0:CELL_STEPS];
   logic [CELL_W-1:0] quo_ff  [0:CELL_STEPS];
   logic [H_W-1:0]    h_ff    [0:CELL_STEPS];
   logic [1:0]        kind_ff [0:CELL_STEPS];

   // stage zero is the input itself
   assign rem_ff[0]  = cell_in;
   assign quo_ff[0]  = '0;
   assign h_ff[0]    = h_in;
   assign kind_ff[0] = kind_in;

   for (genvar k = 1; k <= CELL_STEPS; k++) begin : g_step
      localparam int SH = CELL_STEPS - k;
      logic [CMP_W-1:0] sub_w;
      logic             take;
      assign sub_w = CMP_W'(h_ff[k-1]) << SH;
      assign take  = CMP_W'(rem_ff[k-1]) >= sub_w;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= take ? CELL_W'(CMP_W'(rem_ff[k-1]) - sub_w) : rem_ff[k-1];
            quo_ff[k]  <= quo_ff[k-1] | (CELL_W'(take) << SH);
            h_ff[k]    <= h_ff[k-1];
            kind_ff[k] <= kind_ff[k-1];
         end
      end
   end

   assign res.col  = quo_ff[CELL_STEPS];
   assign res.row  = rem_ff[CELL_STEPS][ROW_W-1:0];
   assign res.kind = kind_ff[CELL_STEPS];

endmodule

>>> hw/rtl/taim_frac_div.sv
// Pipelined restoring divider for the scaled affine numerator, with overflow
// pre-check, round to nearest (ties away) and clamp at 2^40. Depends on taim_pkg.
module taim_frac_div (
   input  logic                            clock,
   input  logic                            en,
   input  logic [taim_pkg::MAG_W-1:0]      num_in,
   input  logic [taim_pkg::DEN_W-1:0]      den_in,
   output logic [taim_pkg::FRAC_STEPS-1:0] mag
);
   import taim_pkg::*;

   localparam int EXT_W = DEN_W + FRAC_STEPS + 1;
   localparam logic [FRAC_STEPS-1:0] Q_LIM = FRAC_STEPS'(1) << (FRAC_STEPS - 1);

   logic [MAG_W-1:0]      rem_ff [0:FRAC_STEPS];
   logic [FRAC_STEPS-1:0] quo_ff [0:FRAC_STEPS];
   logic [DEN_W-1:0]      den_ff [0:FRAC_STEPS];
   logic                  ovf_ff [0:FRAC_STEPS];
   logic [FRAC_STEPS-1:0] mag_ff;

   // quotient of 2^41 or more always clamps
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= num_in;
         quo_ff[0] <= '0;
         den_ff[0] <= den_in;
         ovf_ff[0] <= EXT_W'(num_in) >= (EXT_W'(den_in) << FRAC_STEPS);
      end
   end

   for (genvar k = 1; k <= FRAC_STEPS; k++) begin : g_step
      localparam int SH = FRAC_STEPS - k;
      logic [EXT_W-1:0] sub_w;
      logic             take;
      assign sub_w = EXT_W'(den_ff[k-1]) << SH;
      assign take  = EXT_W'(rem_ff[k-1]) >= sub_w;
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= take ? MAG_W'(EXT_W'(rem_ff[k-1]) - sub_w) : rem_ff[k-1];
            quo_ff[k] <= quo_ff[k-1] | (FRAC_STEPS'(take) << SH);
            den_ff[k] <= den_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
      end
   end

   // round half away on the magnitude, then clamp
   logic                  rnd;
   logic [FRAC_STEPS:0]   quo_rnd;
   logic [FRAC_STEPS-1:0] mag_in;

   always_comb begin
      rnd     = {rem_ff[FRAC_STEPS], 1'b0} >= (MAG_W + 1)'(den_ff[FRAC_STEPS]);
      quo_rnd = (FRAC_STEPS + 1)'(quo_ff[FRAC_STEPS]) + (FRAC_STEPS + 1)'(rnd);
      if (ovf_ff[FRAC_STEPS] || (quo_rnd > (FRAC_STEPS + 1)'(Q_LIM))) begin
         mag_in = Q_LIM;
      end else begin
         mag_in = quo_rnd[FRAC_STEPS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff <= mag_in;
      end
   end

   assign mag = mag_ff;

endmodule

>>> hw/rtl/triangle_affine_inverse_map.sv
// Top level of the triangle inverse affine mapping pipeline.
// Depends on taim_pkg, taim_cell_div and taim_frac_div.
//
// Usage:
//   req_* carries one beat per query: triangle number, three projected
//   vertices and a point, all signed Q16.16. rsp_* returns one beat per
//   query: the preimage in lattice Q16.16 and a degenerate flag, which is
//   set with zero coordinates when the projected triangle has no area.
//   csr_wr_en / csr_wr_data write the grid height (cells along y); write it
//   only while no beat is in flight. Zero acts as 1, values above 512 as 512.
// Throughput and depth:
//   One beat per cycle is sustained while the output is not stalled; the
//   depth is set by the 41-stage quotient pipeline plus the stages of
//   products, setup, rounding and output.
// Reset:
//   synchronous reset empties the pipeline and sets the height to 512.
// Stall:
//   while rsp_valid is high and rsp_ready is low the whole pipeline holds; a one-beat skid register
//   at the input still takes one more beat, and req_ready drops until it drains.
module triangle_affine_inverse_map (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [taim_pkg::ID_W-1:0]          req_triangle_id,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex0_x,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex0_y,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex1_x,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex1_y,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex2_x,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_vertex2_y,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_point_x,
   input  logic signed [taim_pkg::CRD_W-1:0]  req_point_y,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [taim_pkg::CRD_W-1:0]  rsp_preimage_x,
   output logic signed [taim_pkg::CRD_W-1:0]  rsp_preimage_y,
   output logic                               rsp_degenerate,
   input  logic                               csr_wr_en,
   input  logic [taim_pkg::H_W-1:0]           csr_wr_data
);
   import taim_pkg::*;

   localparam logic [2:0] COEF_ZERO = 3'd0;
   localparam logic [2:0] COEF_POS1 = 3'd1;
   localparam logic [2:0] COEF_POS2 = 3'd2;
   localparam logic [2:0] COEF_NEG1 = 3'd3;
   localparam logic [2:0] COEF_NEG2 = 3'd4;
   localparam int OUT_W = FRAC_STEPS + 5;

   function automatic logic signed [CRS_W+1:0] scale_term(
      input logic signed [CRS_W-1:0] v,
      input logic [2:0]              c
   );
      logic signed [CRS_W+1:0] e;
      e = (CRS_W + 2)'(v);
      unique case (c)
         COEF_POS1: scale_term = e;
         COEF_POS2: scale_term = e <<< 1;
         COEF_NEG1: scale_term = -e;
         COEF_NEG2: scale_term = -(e <<< 1);
         default:   scale_term = '0;
      endcase
   endfunction

   // config register
   logic [H_W-1:0] grid_height_ff;
   logic [H_W-1:0] h_clamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_height_ff <= H_W'(MAX_GRID);
      end else if (csr_wr_en) begin
         grid_height_ff <= csr_wr_data;
      end
   end

   always_comb begin
      priority if (grid_height_ff == '0) begin
         h_clamp = H_W'(1);
      end else if (grid_height_ff > H_W'(MAX_GRID)) begin
         h_clamp = H_W'(MAX_GRID);
      end else begin
         h_clamp = grid_height_ff;
      end
   end

   // global advance, input skid
   logic        en;
   logic        rsp_valid_ff;
   logic        skid_full_ff;
   in_beat_type skid_ff;
   in_beat_type req_beat;
   in_beat_type src;
   logic        src_valid;
   logic        req_fire;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_full_ff;
   assign req_fire  = req_valid && req_ready;

   assign req_beat = '{id: req_triangle_id, v0x: req_vertex0_x, v0y: req_vertex0_y,
                       v1x: req_vertex1_x, v1y: req_vertex1_y, v2x: req_vertex2_x,
                       v2y: req_vertex2_y, ptx: req_point_x, pty: req_point_y};
   assign src       = skid_full_ff ? skid_ff : req_beat;
   assign src_valid = skid_full_ff || req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else if (en) begin
         skid_full_ff <= 1'b0;
      end else if (req_fire) begin
         skid_full_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!en && req_fire) begin
         skid_ff <= req_beat;
      end
   end

   // stage A: edge vectors relative to the first vertex
   logic                    valid_a_ff;
   logic signed [DIF_W-1:0] ux_a_ff, uy_a_ff, vx_a_ff, vy_a_ff, wx_a_ff, wy_a_ff;
   logic [CELL_W-1:0]       cell_a_ff;
   logic [H_W-1:0]          h_a_ff;
   logic [1:0]              kind_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux_a_ff   <= DIF_W'(src.v1x) - DIF_W'(src.v0x);
         uy_a_ff   <= DIF_W'(src.v1y) - DIF_W'(src.v0y);
         vx_a_ff   <= DIF_W'(src.v2x) - DIF_W'(src.v0x);
         vy_a_ff   <= DIF_W'(src.v2y) - DIF_W'(src.v0y);
         wx_a_ff   <= DIF_W'(src.ptx) - DIF_W'(src.v0x);
         wy_a_ff   <= DIF_W'(src.pty) - DIF_W'(src.v0y);
         cell_a_ff <= src.id[ID_W-1:2];
         kind_a_ff <= src.id[1:0];
         h_a_ff    <= h_clamp;
      end
   end

   // stage B: six cross-product terms
   logic                    valid_b_ff;
   logic [1:0]              kind_b_ff;
   logic signed [PRD_W-1:0] d0_b_ff, d1_b_ff, b0_b_ff, b1_b_ff, c0_b_ff, c1_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_b_ff <= kind_a_ff;
         d0_b_ff   <= ux_a_ff * vy_a_ff;
         d1_b_ff   <= uy_a_ff * vx_a_ff;
         b0_b_ff   <= wx_a_ff * vy_a_ff;
         b1_b_ff   <= wy_a_ff * vx_a_ff;
         c0_b_ff   <= ux_a_ff * wy_a_ff;
         c1_b_ff   <= uy_a_ff * wx_a_ff;
      end
   end

   // stage C: determinant and barycentric numerators
   logic                    valid_c_ff;
   logic [1:0]              kind_c_ff;
   logic signed [CRS_W-1:0] det_c_ff, nb_c_ff, nc_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_c_ff <= valid_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kind_c_ff <= kind_b_ff;
         det_c_ff  <= CRS_W'(d0_b_ff) - CRS_W'(d1_b_ff);
         nb_c_ff   <= CRS_W'(b0_b_ff) - CRS_W'(b1_b_ff);
         nc_c_ff   <= CRS_W'(c0_b_ff) - CRS_W'(c1_b_ff);
      end
   end

   // stage D: combine with vertex offsets (half units), scale by 2^15
   logic [2:0]              cqx, crx, cqy, cry;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic                    valid_d_ff;
   logic signed [NUM_W-1:0] numx_d_ff, numy_d_ff;
   logic signed [CRS_W-1:0] det_d_ff;

   always_comb begin
      unique case (kind_c_ff)
         KIND_BOTTOM: begin cqx = COEF_POS1; cqy = COEF_POS1; crx = COEF_POS2; cry = COEF_ZERO; end
         KIND_LEFT:   begin cqx = COEF_ZERO; cqy = COEF_POS2; crx = COEF_POS1; cry = COEF_POS1; end
         KIND_RIGHT:  begin cqx = COEF_POS1; cqy = COEF_POS1; crx = COEF_POS1; cry = COEF_NEG1; end
         default:     begin cqx = COEF_POS2; cqy = COEF_ZERO; crx = COEF_POS1; cry = COEF_NEG1; end
      endcase
      sum_x = SUM_W'(scale_term(nb_c_ff, cqx)) + SUM_W'(scale_term(nc_c_ff, crx));
      sum_y = SUM_W'(scale_term(nb_c_ff, cqy)) + SUM_W'(scale_term(nc_c_ff, cry));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= valid_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         numx_d_ff <= {sum_x, 15'b0};
         numy_d_ff <= {sum_y, 15'b0};
         det_d_ff  <= det_c_ff;
      end
   end

   // stage E: magnitudes and signs for the dividers
   side_type         side_e_ff;
   logic [MAG_W-1:0] magx_e_ff, magy_e_ff;
   logic [DEN_W-1:0] den_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_e_ff <= '0;
      end else if (en) begin
         side_e_ff.valid <= valid_d_ff;
         side_e_ff.neg_x <= numx_d_ff[NUM_W-1] ^ det_d_ff[CRS_W-1];
         side_e_ff.neg_y <= numy_d_ff[NUM_W-1] ^ det_d_ff[CRS_W-1];
         side_e_ff.zero  <= det_d_ff == '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         magx_e_ff <= numx_d_ff[NUM_W-1] ? MAG_W'(-numx_d_ff) : MAG_W'(numx_d_ff);
         magy_e_ff <= numy_d_ff[NUM_W-1] ? MAG_W'(-numy_d_ff) : MAG_W'(numy_d_ff);
         den_e_ff  <= det_d_ff[CRS_W-1] ? DEN_W'(-det_d_ff) : DEN_W'(det_d_ff);
      end
   end

   // dividers
   logic [FRAC_STEPS-1:0] qx_mag, qy_mag;

   taim_frac_div u_div_x (
      .clock  (clock),
      .en     (en),
      .num_in (magx_e_ff),
      .den_in (den_e_ff),
      .mag    (qx_mag)
   );

   taim_frac_div u_div_y (
      .clock  (clock),
      .en     (en),
      .num_in (magy_e_ff),
      .den_in (den_e_ff),
      .mag    (qy_mag)
   );

   cell_res_type cell_res;

   taim_cell_div u_cell_div (
      .clock   (clock),
      .en      (en),
      .cell_in (cell_a_ff),
      .h_in    (h_a_ff),
      .kind_in (kind_a_ff),
      .res     (cell_res)
   );

   // align sideband and lattice cell with the quotients
   side_type     side_ff [0:FRAC_LAT-1];
   cell_res_type cell_ff [0:CELL_DELAY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < FRAC_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else if (en) begin
         side_ff[0] <= side_e_ff;
         for (int k = 1; k < FRAC_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cell_ff[0] <= cell_res;
         for (int k = 1; k < CELL_DELAY; k++) begin
            cell_ff[k] <= cell_ff[k-1];
         end
      end
   end

   // final: vertex P plus signed quotient, saturate to Q16.16
   side_type                side_f;
   cell_res_type            cell_f;
   logic [CELL_W+1:0]       px2, py2;
   logic signed [OUT_W-1:0] sum_ox, sum_oy;
   logic signed [CRD_W-1:0] pre_x_in, pre_y_in;

   function automatic logic signed [CRD_W-1:0] sat32(input logic signed [OUT_W-1:0] v);
      priority if (v > OUT_W'(64'sd2147483647)) begin
         sat32 = {1'b0, {(CRD_W-1){1'b1}}};
      end else if (v < -OUT_W'(64'sd2147483648)) begin
         sat32 = {1'b1, {(CRD_W-1){1'b0}}};
      end else begin
         sat32 = v[CRD_W-1:0];
      end
   endfunction

   always_comb begin
      side_f = side_ff[FRAC_LAT-1];
      cell_f = cell_ff[CELL_DELAY-1];
      px2    = {1'b0, cell_f.col, 1'b0} + (CELL_W + 2)'(cell_f.kind == KIND_RIGHT);
      py2    = (CELL_W + 2)'({cell_f.row, 1'b0});
      unique case (cell_f.kind)
         KIND_RIGHT: py2 = py2 + (CELL_W + 2)'(1);
         KIND_TOP:   py2 = py2 + (CELL_W + 2)'(2);
         default:    py2 = py2;
      endcase
      sum_ox = OUT_W'({px2, 15'b0})
             + (side_f.neg_x ? -OUT_W'(qx_mag) : OUT_W'(qx_mag));
      sum_oy = OUT_W'({py2, 15'b0})
             + (side_f.neg_y ? -OUT_W'(qy_mag) : OUT_W'(qy_mag));
      pre_x_in = side_f.zero ? '0 : sat32(sum_ox);
      pre_y_in = side_f.zero ? '0 : sat32(sum_oy);
   end

   // output register
   logic signed [CRD_W-1:0] pre_x_ff, pre_y_ff;
   logic                    degen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_f.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_x_ff <= pre_x_in;
         pre_y_ff <= pre_y_in;
         degen_ff <= side_f.zero;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_preimage_x = pre_x_ff;
   assign rsp_preimage_y = pre_y_ff;
   assign rsp_degenerate = degen_ff;

   // checks
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> (rsp_preimage_x == 0) && (rsp_preimage_y == 0))
      else $error("degenerate beat with nonzero coordinates");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !en |=> skid_full_ff && $stable(skid_ff))
      else $error("skid beat lost during stall");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid_ff && !skid_full_ff)
      else $error("pipeline not empty after reset");

endmodule
